[sv/linear_probe_hash_table_assert.svh]
// ----------------------------------------------------------------------------
// linear probe hash table assertion macros
// shared property forms for the hash table checks
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LPHT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("linear probe hash table check failed");

// next-cycle implication, disabled while in reset
`define LPHT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("linear probe hash table check failed");

`endif

[sv/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg
// types and constants shared by the hash table modules
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned CFG_W    = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_BAD_HOME  = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e             command;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot_index;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic    latch_req;
    logic    load_home;
    logic    advance;
    logic    latch_res;
    logic    wr_en;
    logic    wr_res;
    logic    wr_home;
    logic    set_valid;
    logic    clr_valid;
    logic    emit;
    logic    emit_home;
    status_e emit_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hash_done;
    logic home_bad;
    logic hit;
    logic slot_free;
    logic last_probe;
    logic res_moves;
    cmd_e cmd;
  } dp_stat_t;

endpackage

[sv/lpht_mod_unit.sv]
// ----------------------------------------------------------------------------
// lpht_mod_unit
// remainder of the key by the hash modulus: reciprocal multiply, then
// multiply back and subtract, each stage registered after start
// ----------------------------------------------------------------------------
module lpht_mod_unit #(
  parameter int unsigned MODULUS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [lpht_pkg::KEY_W-1:0]     key_i,
  output logic                           done_o,
  output logic [((MODULUS > 1) ? $clog2(MODULUS) : 1)-1:0] rem_o
);

  localparam int unsigned RW = (MODULUS > 1) ? $clog2(MODULUS) : 1;
  localparam int unsigned KW = lpht_pkg::KEY_W;
  // shift of key width plus ceil(log2 modulus) keeps the quotient exact for every key
  localparam int unsigned LW = (MODULUS > 1) ? $clog2(MODULUS) : 0;
  localparam int unsigned SH = KW + LW;
  localparam int unsigned MW = KW + 1;
  localparam int unsigned PW = KW + MW;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(MODULUS) - 64'd1) / 64'(MODULUS);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

  logic          stage1_q;
  logic          stage2_q;
  logic [KW-1:0] key_q;
  logic [PW-1:0] prod_q;
  logic [KW-1:0] quot;
  logic [KW-1:0] back;
  logic [KW-1:0] diff;
  logic [RW-1:0] rem_q;

  assign quot = KW'(prod_q >> SH);
  assign back = quot * KW'(MODULUS);
  assign diff = key_q - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage1_q <= 1'b0;
      stage2_q <= 1'b0;
    end else begin
      stage1_q <= start_i;
      stage2_q <= stage1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    if (stage1_q) begin
      prod_q <= PW'(key_q) * PW'(RECIP);
    end
    if (stage2_q) begin
      rem_q <= RW'(diff);
    end
  end

  assign done_o = stage2_q;
  assign rem_o  = rem_q;

endmodule

[sv/lpht_datapath.sv]
// ----------------------------------------------------------------------------
// lpht_datapath
// key store, valid bits, probe pointer and result register
// ----------------------------------------------------------------------------
module lpht_datapath #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned HASH_MODULUS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpht_pkg::req_t             req_i,
  input  logic [lpht_pkg::CFG_W-1:0] table_size_i,
  input  lpht_pkg::dp_cmd_t          cmd_i,
  output lpht_pkg::dp_stat_t         stat_o,
  output logic                       rsp_valid_o,
  output lpht_pkg::rsp_t             rsp_o
);

  localparam int unsigned KW = lpht_pkg::KEY_W;
  localparam int unsigned RW = (HASH_MODULUS > 1) ? $clog2(HASH_MODULUS) : 1;
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam int unsigned SW = (lpht_pkg::CFG_W > NW) ? lpht_pkg::CFG_W : NW;
  localparam int unsigned CW = (RW > NW) ? RW : NW;

  // key store and stored home of each key
  logic [KW-1:0]    keys_mem  [DEPTH];
  logic [RW-1:0]    homes_mem [DEPTH];
  logic [KW-1:0]    key_rd_q;
  logic [RW-1:0]    home_rd_q;
  logic [DEPTH-1:0] valid_q;

  lpht_pkg::cmd_e   cmd_q;
  logic [KW-1:0]    key_q;
  logic [RW-1:0]    home_q;
  logic [KW-1:0]    res_key_q;
  logic [RW-1:0]    res_home_q;
  logic [PW-1:0]    ptr_q, ptr_d, ptr_nxt;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic [NW-1:0]    n;
  logic [NW-1:0]    ptr_inc;
  logic [RW-1:0]    rem;
  logic             hash_done;

  logic [PW-1:0]    wr_addr;
  logic [KW-1:0]    wr_key;
  logic [RW-1:0]    wr_hm;

  logic                 rsp_valid_q;
  lpht_pkg::rsp_t       rsp_q;

  lpht_mod_unit #(
    .MODULUS (HASH_MODULUS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.latch_req),
    .key_i   (req_i.key),
    .done_o  (hash_done),
    .rem_o   (rem)
  );

  // size in use, saturated at the store depth
  assign n = (SW'(table_size_i) > SW'(DEPTH)) ? NW'(DEPTH) : NW'(table_size_i);

  // circular step within the size in use
  assign ptr_inc = NW'(ptr_q) + NW'(1);
  assign ptr_nxt = (ptr_inc == n) ? '0 : PW'(ptr_inc);

  always_comb begin
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    if (cmd_i.load_home) begin
      ptr_d = PW'(rem);
      cnt_d = '0;
    end else if (cmd_i.advance) begin
      ptr_d = ptr_nxt;
      cnt_d = cnt_q + NW'(1);
    end
  end

  assign wr_addr = cmd_i.wr_home ? PW'(home_q) : ptr_q;
  assign wr_key  = cmd_i.wr_res ? res_key_q : key_q;
  assign wr_hm   = cmd_i.wr_res ? res_home_q : home_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      cnt_q       <= '0;
      valid_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= cmd_i.emit;
      if (cmd_i.set_valid) begin
        valid_q[wr_addr] <= 1'b1;
      end else if (cmd_i.clr_valid) begin
        valid_q[ptr_q] <= 1'b0;
      end
    end
  end

  // store: one write port, read data registered at the next pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      keys_mem[wr_addr]  <= wr_key;
      homes_mem[wr_addr] <= wr_hm;
    end
    key_rd_q  <= keys_mem[ptr_d];
    home_rd_q <= homes_mem[ptr_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      cmd_q <= req_i.command;
      key_q <= req_i.key;
    end
    if (cmd_i.load_home) begin
      home_q <= rem;
    end
    if (cmd_i.latch_res) begin
      res_key_q  <= key_rd_q;
      res_home_q <= home_rd_q;
    end
    if (cmd_i.emit) begin
      rsp_q.status <= cmd_i.emit_status;
      if (cmd_i.emit_status == lpht_pkg::ST_DONE) begin
        rsp_q.slot_index <= cmd_i.emit_home ? lpht_pkg::SLOT_W'(home_q)
                                            : lpht_pkg::SLOT_W'(ptr_q);
      end else begin
        rsp_q.slot_index <= '0;
      end
    end
  end

  assign stat_o.hash_done  = hash_done;
  assign stat_o.home_bad   = CW'(rem) >= CW'(n);
  assign stat_o.hit        = valid_q[ptr_q] && (key_rd_q == key_q);
  assign stat_o.slot_free  = !valid_q[ptr_q];
  assign stat_o.last_probe = cnt_q == (n - NW'(1));
  assign stat_o.res_moves  = res_home_q != home_q;
  assign stat_o.cmd        = cmd_q;

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

[sv/lpht_ctrl.sv]
// ----------------------------------------------------------------------------
// lpht_ctrl
// sequencer for hashing, probing, placement and relocation
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  lpht_pkg::dp_stat_t stat_i,
  output lpht_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HASH  = 6'b000010,
    S_CHECK = 6'b000100,
    S_PROBE = 6'b001000,
    S_FREE  = 6'b010000,
    S_MOVE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch_req = 1'b1;
          state_d         = S_HASH;
        end
      end
      S_HASH: begin
        if (stat_i.hash_done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.load_home = 1'b1;
        if (stat_i.cmd != lpht_pkg::CMD_INSERT && stat_i.cmd != lpht_pkg::CMD_SEARCH &&
            stat_i.cmd != lpht_pkg::CMD_DELETE) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = lpht_pkg::ST_NOT_FOUND;
          state_d           = S_IDLE;
        end else if (stat_i.home_bad) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = lpht_pkg::ST_BAD_HOME;
          state_d           = S_IDLE;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat_i.cmd == lpht_pkg::CMD_INSERT) begin
          // home slot check
          if (stat_i.slot_free) begin
            cmd_o.wr_en       = 1'b1;
            cmd_o.set_valid   = 1'b1;
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = lpht_pkg::ST_DONE;
            state_d           = S_IDLE;
          end else if (stat_i.last_probe) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = lpht_pkg::ST_OVERFLOW;
            state_d           = S_IDLE;
          end else begin
            cmd_o.latch_res = 1'b1;
            cmd_o.advance   = 1'b1;
            state_d         = S_FREE;
          end
        end else begin
          if (stat_i.hit) begin
            cmd_o.clr_valid   = stat_i.cmd == lpht_pkg::CMD_DELETE;
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = lpht_pkg::ST_DONE;
            state_d           = S_IDLE;
          end else if (stat_i.last_probe) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = lpht_pkg::ST_NOT_FOUND;
            state_d           = S_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      S_FREE: begin
        if (stat_i.slot_free) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.set_valid = 1'b1;
          if (stat_i.res_moves) begin
            // resident away from its home gives way
            cmd_o.wr_res = 1'b1;
            state_d      = S_MOVE;
          end else begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = lpht_pkg::ST_DONE;
            state_d           = S_IDLE;
          end
        end else if (stat_i.last_probe) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = lpht_pkg::ST_OVERFLOW;
          state_d           = S_IDLE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      S_MOVE: begin
        cmd_o.wr_en       = 1'b1;
        cmd_o.wr_home     = 1'b1;
        cmd_o.emit        = 1'b1;
        cmd_o.emit_home   = 1'b1;
        cmd_o.emit_status = lpht_pkg::ST_DONE;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = state_q != S_IDLE;

endmodule

[sv/linear_probe_hash_table.sv]
// an unknown command or a bad home slot is answered from the check state after hashing;
//   search, delete and insert probe up to n slots in use, one a cycle; insert may relocate
// the remainder is computed in steps: reciprocal multiply, then multiply back and subtract
// one operation at a time: busy falls in the strobe cycle and a new start is taken at its
//   closing edge; no result stall
// reset: all valid bits clear at once (empty table), table_size returns to 10, no sweep
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open-addressed key table with linear probing and displacement of off-home keys
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned HASH_MODULUS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command transfer
  input  logic                       start,
  output logic                       busy,
  input  lpht_pkg::req_t             req_i,
  // result transfer, one cycle, cannot be held off
  output logic                       rsp_valid_o,
  output lpht_pkg::rsp_t             rsp_o,
  // table_size register
  input  logic                       cfg_we_i,
  input  logic [lpht_pkg::CFG_W-1:0] cfg_wdata_i
);

  // table size in use; the user writes it only while the table is idle, the block does not enforce it
  logic [lpht_pkg::CFG_W-1:0] table_size_q;

  // command and status between sequencer and datapath
  lpht_pkg::dp_cmd_t  dp_cmd;
  lpht_pkg::dp_stat_t dp_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= lpht_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  // sequencer: hash, home check, probe, free slot search, relocation
  lpht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd)
  );

  // datapath: key store, valid bits, probe pointer, result register
  lpht_datapath #(
    .DEPTH        (DEPTH),
    .HASH_MODULUS (HASH_MODULUS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .table_size_i (table_size_q),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .rsp_valid_o  (rsp_valid_o),
    .rsp_o        (rsp_o)
  );

  // a command transfer always starts work
  `LPHT_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  // the table is idle again when its result shows
  `LPHT_ASSERT_IMP(a_strobe_idle, clk_i, rst_ni, rsp_valid_o, !busy)
  // results never come in consecutive cycles
  `LPHT_ASSERT_IMP(a_strobe_single, clk_i, rst_ni, rsp_valid_o, !$past(rsp_valid_o))
  // only a completed operation names a slot
  `LPHT_ASSERT_IMP(a_slot_zero, clk_i, rst_ni,
    rsp_valid_o && rsp_o.status != lpht_pkg::ST_DONE, rsp_o.slot_index == '0)

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the hash table one command transfer at a time against a local
// table model: a short directed list of commands, then random phases, one
// for each table size
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SLOTS    = 16;
  localparam int unsigned HOME_MOD = 10;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS = 100;

  // the fourth command code is outside cmd_e but fits the field
  localparam logic [lpht_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_e;

  // one line of the directed list: a command, or a table_size write
  typedef struct {
    row_kind_e                  kind;
    logic [lpht_pkg::CFG_W-1:0] size;
    logic [lpht_pkg::CMD_W-1:0] cmd;
    logic [lpht_pkg::KEY_W-1:0] key;
    bit                         typed;
    lpht_pkg::rsp_t             rsp;
  } stim_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  lpht_pkg::req_t             req_i;
  logic                       rsp_valid_o;
  lpht_pkg::rsp_t             rsp_o;
  logic                       cfg_we_i;
  logic [lpht_pkg::CFG_W-1:0] cfg_wdata_i;

  // local copy of the table and of the size register
  logic [lpht_pkg::KEY_W-1:0] slot_key  [SLOTS];
  bit                         slot_used [SLOTS];
  logic [lpht_pkg::CFG_W-1:0] size_reg;

  lpht_pkg::rsp_t             result_q [$];
  stim_row_t                  dir_rows [$];
  logic [lpht_pkg::KEY_W-1:0] key_pool [$];

  // typed-in expectation for the command being offered
  bit             row_typed;
  lpht_pkg::rsp_t typed_rsp;
  bit             idle_on;

  int unsigned    errors;
  int unsigned    stall_count;
  lpht_pkg::rsp_t want;
  lpht_pkg::rsp_t pred;

  always #2 clk_i = ~clk_i;

  linear_probe_hash_table #(
    .DEPTH       (SLOTS),
    .HASH_MODULUS(HOME_MOD)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
    errors++;
  endtask

  // works out the result of one command and applies it to the local table
  function automatic lpht_pkg::rsp_t probe_predict(logic [lpht_pkg::CMD_W-1:0] cmd,
                                                   logic [lpht_pkg::KEY_W-1:0] k);
    int unsigned       n;
    int unsigned       home;
    int unsigned       s;
    int unsigned       d;
    int unsigned       slot;
    lpht_pkg::status_e st;
    lpht_pkg::rsp_t    r;
    n    = (size_reg > SLOTS) ? SLOTS : size_reg;
    home = k % HOME_MOD;
    st   = lpht_pkg::ST_NOT_FOUND;
    slot = 0;
    if (cmd == CMD_UNKNOWN) begin
      st = lpht_pkg::ST_NOT_FOUND;
    end else if (home >= n) begin
      // covers a zero table size too
      st = lpht_pkg::ST_BAD_HOME;
    end else if (cmd == lpht_pkg::CMD_INSERT) begin
      if (!slot_used[home]) begin
        slot_key[home]  = k;
        slot_used[home] = 1'b1;
        st   = lpht_pkg::ST_DONE;
        slot = home;
      end else begin
        // next free slot after home, circular within n
        s = n;
        for (d = 1; d < n && s == n; d++) begin
          if (!slot_used[(home + d) % n]) s = (home + d) % n;
        end
        if (s >= n) begin
          // full: nothing moves
          st = lpht_pkg::ST_OVERFLOW;
        end else if (slot_key[home] % HOME_MOD != home) begin
          // resident is away from its own home, so it gives way
          slot_key[s]    = slot_key[home];
          slot_used[s]   = 1'b1;
          slot_key[home] = k;
          st   = lpht_pkg::ST_DONE;
          slot = home;
        end else begin
          slot_key[s]  = k;
          slot_used[s] = 1'b1;
          st   = lpht_pkg::ST_DONE;
          slot = s;
        end
      end
    end else begin
      // search and delete scan every slot from home, holes and all
      s = n;
      for (d = 0; d < n && s == n; d++) begin
        if (slot_used[(home + d) % n] && slot_key[(home + d) % n] == k) s = (home + d) % n;
      end
      if (s < n) begin
        if (cmd == lpht_pkg::CMD_DELETE) slot_used[s] = 1'b0;
        st   = lpht_pkg::ST_DONE;
        slot = s;
      end
    end
    r.status     = st;
    r.slot_index = slot[lpht_pkg::SLOT_W-1:0];
    return r;
  endfunction

  // result check first, then the new expectation: both can fall on one edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with no command pending, status", rsp_o.status, -1);
        end else begin
          want = result_q.pop_front();
          if (rsp_o.status !== want.status)
            report_mismatch("status", rsp_o.status, want.status);
          if (rsp_o.slot_index !== want.slot_index)
            report_mismatch("slot_index", rsp_o.slot_index, want.slot_index);
        end
      end
      if (start && !busy) begin
        pred = probe_predict(req_i.command, req_i.key);
        result_q.push_back(row_typed ? typed_rsp : pred);
      end
    end
  end

  // watchdog: cycles in which neither a command nor a result is transferred
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || rsp_valid_o) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // offers one command, with an optional idle gap first; returns on a falling edge
  task automatic send_item(logic [lpht_pkg::CMD_W-1:0] cmd, logic [lpht_pkg::KEY_W-1:0] k,
                           bit typed, lpht_pkg::rsp_t typed_val);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(99) < 19)
      gap = ($urandom_range(9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    row_typed = typed;
    typed_rsp = typed_val;
    start <= 1'b1;
    req_i <= lpht_pkg::req_t'({cmd, k});
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // holds off until every expected result has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (result_q.size() != 0 || busy) @(negedge clk_i);
  endtask

  // table_size write, only while the block is idle
  task automatic write_size(logic [lpht_pkg::CFG_W-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = v;
  endtask

  task automatic add_item(logic [lpht_pkg::CMD_W-1:0] cmd, logic [lpht_pkg::KEY_W-1:0] k,
                          bit typed = 1'b0,
                          lpht_pkg::status_e st = lpht_pkg::ST_DONE,
                          logic [lpht_pkg::SLOT_W-1:0] slot = '0);
    stim_row_t r;
    r.kind           = ROW_ITEM;
    r.size           = '0;
    r.cmd            = cmd;
    r.key            = k;
    r.typed          = typed;
    r.rsp.status     = st;
    r.rsp.slot_index = slot;
    dir_rows.push_back(r);
  endtask

  task automatic add_size(logic [lpht_pkg::CFG_W-1:0] v);
    stim_row_t r;
    r.kind  = ROW_SIZE;
    r.size  = v;
    r.cmd   = '0;
    r.key   = '0;
    r.typed = 1'b0;
    r.rsp   = '0;
    dir_rows.push_back(r);
  endtask

  // mostly keys already in play or with small values, so the table fills up
  function automatic logic [lpht_pkg::KEY_W-1:0] pick_key();
    int unsigned r;
    logic [lpht_pkg::KEY_W-1:0] k;
    r = $urandom_range(99);
    if (r < 40 && key_pool.size() != 0) k = key_pool[$urandom_range(key_pool.size() - 1)];
    else if (r < 80) k = lpht_pkg::KEY_W'($urandom_range(0, 59));
    else if (r < 85) k = {lpht_pkg::KEY_W{1'b1}} - lpht_pkg::KEY_W'($urandom_range(0, 9));
    else k = lpht_pkg::KEY_W'($urandom());
    return k;
  endfunction

  function automatic logic [lpht_pkg::CMD_W-1:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return lpht_pkg::CMD_INSERT;
    if (r < 65) return lpht_pkg::CMD_SEARCH;
    if (r < 95) return lpht_pkg::CMD_DELETE;
    return CMD_UNKNOWN;
  endfunction

  logic [lpht_pkg::CFG_W-1:0] phase_size [8];
  logic [lpht_pkg::CMD_W-1:0] cmd;
  logic [lpht_pkg::KEY_W-1:0] k;

  initial begin
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    errors      = 0;
    row_typed   = 1'b0;
    typed_rsp   = '0;
    idle_on     = 1'b1;
    size_reg    = lpht_pkg::CFG_RESET;
    foreach (slot_used[i]) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
    end
    phase_size = '{5'd16, 5'd31, 5'd10, 5'd1, 5'd0, 5'd12, 5'd5, 5'd20};

    // directed list, starting from the reset size of ten slots
    add_item(lpht_pkg::CMD_SEARCH, 31'd5, 1'b1, lpht_pkg::ST_NOT_FOUND, 4'd0); // empty table
    add_item(lpht_pkg::CMD_DELETE, 31'd7, 1'b1, lpht_pkg::ST_NOT_FOUND, 4'd0);
    add_item(lpht_pkg::CMD_INSERT, 31'd0, 1'b1, lpht_pkg::ST_DONE, 4'd0);
    add_item(lpht_pkg::CMD_INSERT, 31'h7fff_ffff, 1'b1, lpht_pkg::ST_DONE, 4'd7); // largest key
    add_item(lpht_pkg::CMD_INSERT, 31'd10);              // home taken by a home key
    add_item(lpht_pkg::CMD_INSERT, 31'd1);               // displaces the off-home key
    add_item(lpht_pkg::CMD_INSERT, 31'd0);               // duplicate
    add_item(lpht_pkg::CMD_SEARCH, 31'd10);
    add_item(lpht_pkg::CMD_DELETE, 31'd0);               // first match only
    add_item(lpht_pkg::CMD_SEARCH, 31'd0);               // finds the duplicate past a hole
    add_item(CMD_UNKNOWN, 31'd5, 1'b1, lpht_pkg::ST_NOT_FOUND, 4'd0);
    add_size(5'd0);
    add_item(lpht_pkg::CMD_INSERT, 31'd0, 1'b1, lpht_pkg::ST_BAD_HOME, 4'd0);
    add_size(5'd1);
    add_item(lpht_pkg::CMD_INSERT, 31'd3, 1'b1, lpht_pkg::ST_BAD_HOME, 4'd0);
    add_item(lpht_pkg::CMD_INSERT, 31'd0);
    add_item(lpht_pkg::CMD_INSERT, 31'd20);              // one-slot table is full
    add_size(5'd31);                                     // saturates to sixteen
    add_item(lpht_pkg::CMD_INSERT, 31'd9);
    add_item(lpht_pkg::CMD_INSERT, 31'd19);
    add_item(lpht_pkg::CMD_INSERT, 31'd29);
    add_item(lpht_pkg::CMD_SEARCH, 31'd29);
    add_item(lpht_pkg::CMD_SEARCH, 31'h7fff_fffe);
    add_size(5'd16);
    add_item(lpht_pkg::CMD_DELETE, 31'd19);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SIZE) write_size(dir_rows[i].size);
      else send_item(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].rsp);
    end

    // random phases, one table size each; the third runs with no idling
    foreach (phase_size[p]) begin
      write_size(phase_size[p]);
      idle_on = (p != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        cmd = pick_cmd();
        k   = pick_key();
        if (cmd == lpht_pkg::CMD_INSERT) begin
          key_pool.push_back(k);
          if (key_pool.size() > 48) key_pool.delete(0);
        end
        send_item(cmd, k, 1'b0, '0);
        // in the sixth phase the sender holds back mid-phase until the block has answered everything
        if (p == 5 && i == PHASE_ITEMS / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
